// ===== design/ctd_pkg.sv =====
// Package for the context tANS byte decoder.
// Holds table geometry, request codes, table word layout and lane context types.
// No dependencies.
`timescale 1ns / 1ps

package ctd_pkg;

  // Table geometry and lane count
  localparam int unsigned TABLE_LOG = 11;
  localparam int unsigned LANES     = 8;
  localparam int unsigned STATE_W   = TABLE_LOG;
  localparam int unsigned CARRY_W   = 2;
  localparam int unsigned TBL_AW    = CARRY_W + TABLE_LOG;
  localparam int unsigned LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;

  // Field widths of the transfers
  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned LSEL_W  = 3;
  localparam int unsigned BANK_W  = 2;
  localparam int unsigned TIDX_W  = 11;
  localparam int unsigned WORD_W  = 23;
  localparam int unsigned SBITS_W = 11;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NB_W    = 4;

  // Table word layout: symbol, bit count, base
  localparam int unsigned SYM_LSB  = 0;
  localparam int unsigned NB_LSB   = 8;
  localparam int unsigned BASE_LSB = 12;
  localparam int unsigned BASE_W   = WORD_W - BASE_LSB;

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_START  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_DECODE = 2'd2;

  // Carry a started lane gets under the mirror recipe
  localparam logic [CARRY_W-1:0] MIRROR_CARRY = 2'd3;

  // Per-lane decoder context
  typedef struct packed {
    logic [CARRY_W-1:0] carry;
    logic [STATE_W-1:0] state;
  } lane_ctx_t;

  // Lane context write (also used as the forwarding source)
  typedef struct packed {
    logic              en;
    logic [LANE_W-1:0] lane;
    lane_ctx_t         ctx;
  } lane_wr_t;

endpackage

// ===== design/ctd_if.sv =====
// Valid/ready channel interfaces for decoder requests and results.
// Depends on ctd_pkg for field widths.
`timescale 1ns / 1ps

interface ctd_req_if import ctd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  req_type;
  logic [LSEL_W-1:0]  lane;
  logic [BANK_W-1:0]  bank_select;
  logic [TIDX_W-1:0]  table_index;
  logic [WORD_W-1:0]  table_word;
  logic [SBITS_W-1:0] stream_bits;

  modport source (output valid, req_type, lane, bank_select, table_index,
                  table_word, stream_bits, input ready);
  modport sink   (input valid, req_type, lane, bank_select, table_index,
                  table_word, stream_bits, output ready);
endinterface

interface ctd_rsp_if import ctd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic [NB_W-1:0]   bits_used;

  modport source (output valid, out_byte, byte_valid, bits_used, input ready);
  modport sink   (input valid, out_byte, byte_valid, bits_used, output ready);
endinterface

// ===== design/ctd_table_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are not reset.
`timescale 1ns / 1ps

module ctd_table_ram #(
  parameter int unsigned AW = 13,
  parameter int unsigned DW = 23
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1 << AW)-1];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ctd_lane_file.sv =====
// Lane context register file: carry and state for each interleaved lane.
// Depends on ctd_pkg; cleared to zero by reset.
`timescale 1ns / 1ps

module ctd_lane_file import ctd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [LANE_W-1:0] rd_lane,
  output lane_ctx_t         rd_ctx,
  input  lane_wr_t          wr
);

  lane_ctx_t ctx [LANES];

  // Write port
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < int'(LANES); i++) begin
        ctx[i] <= '0;
      end
    end else if (wr.en) begin
      ctx[wr.lane] <= wr.ctx;
    end
  end

  // Read port
  assign rd_ctx = ctx[rd_lane];

endmodule

// ===== design/context_tans_byte_decoder_unit.sv =====
// Context tANS byte decoder top level.
// Path: table read into the step stage, then the output register, then result transfer.
// Throughput: one item per cycle unless the result channel stalls, also back to back on
//   one lane; the limit is the table RAM read, whose next address is forwarded from the step stage.
// Reset: clears lane states, carries, mirrored and pipeline valids; the decode
//   table is not cleared and is undefined until loaded.
`timescale 1ns / 1ps

module context_tans_byte_decoder_unit import ctd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ctd_req_if.sink      req,
  ctd_rsp_if.source    rsp,
  input  logic         cfg_we,
  input  logic         cfg_data
);

  logic mirrored;

  // Step stage (table data arrives here)
  logic               s1_valid;
  logic [TYPE_W-1:0]  s1_type;
  logic [LANE_W-1:0]  s1_lane;
  logic               s1_lane_ok;
  logic [STATE_W-1:0] s1_bits;

  // Output register
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_bvalid;
  logic [NB_W-1:0]   out_bits;

  logic               accept;
  logic               s1_adv;
  logic [LANE_W-1:0]  in_lane;
  logic               in_lane_ok;
  lane_ctx_t          file_ctx;
  lane_ctx_t          cur_ctx;
  lane_wr_t           s1_wr;
  lane_wr_t           file_wr;
  logic               tbl_we;
  logic               tbl_re;
  logic [TBL_AW-1:0]  tbl_waddr;
  logic [TBL_AW-1:0]  tbl_raddr;
  logic [WORD_W-1:0]  tbl_rdata;

  logic [BYTE_W-1:0]  sym;
  logic [NB_W-1:0]    nb_raw;
  logic [NB_W-1:0]    nb;
  logic [NB_W-1:0]    shamt;
  logic [STATE_W-1:0] base;
  logic [STATE_W-1:0] rd_bits;
  logic [BYTE_W-1:0]  res_byte;
  logic               res_bvalid;
  logic [NB_W-1:0]    res_bits;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      mirrored <= 1'b0;
    end else if (cfg_we) begin
      mirrored <= cfg_data;
    end
  end

  // Handshakes
  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign accept    = req.valid && req.ready;

  assign in_lane    = req.lane[LANE_W-1:0];
  assign in_lane_ok = int'(req.lane) < int'(LANES);

  // Lane context lookup with forwarding from the step stage
  ctd_lane_file u_lanes (
    .clk     (clk),
    .rst     (rst),
    .rd_lane (in_lane),
    .rd_ctx  (file_ctx),
    .wr      (file_wr)
  );

  assign cur_ctx = (s1_wr.en && s1_wr.lane == in_lane) ? s1_wr.ctx : file_ctx;

  // Table RAM: loads write, decodes read at (carry, state)
  assign tbl_we    = accept && req.req_type == REQ_LOAD;
  assign tbl_waddr = {req.bank_select, STATE_W'(req.table_index)};
  assign tbl_re    = accept && req.req_type == REQ_DECODE && in_lane_ok;
  assign tbl_raddr = {cur_ctx.carry, cur_ctx.state};

  ctd_table_ram #(.AW(TBL_AW), .DW(WORD_W)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (req.table_word),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Step stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_type    <= req.req_type;
      s1_lane    <= in_lane;
      s1_lane_ok <= in_lane_ok;
      s1_bits    <= STATE_W'(req.stream_bits);
    end
  end

  // Decode step: clamp bit count, take leading stream bits, add base
  assign sym     = tbl_rdata[SYM_LSB +: BYTE_W];
  assign nb_raw  = tbl_rdata[NB_LSB +: NB_W];
  assign nb      = (nb_raw > NB_W'(TABLE_LOG)) ? NB_W'(TABLE_LOG) : nb_raw;
  assign shamt   = NB_W'(TABLE_LOG) - nb;
  assign base    = STATE_W'(tbl_rdata[BASE_LSB +: BASE_W]);
  assign rd_bits = s1_bits >> shamt;

  // Pending lane update of the item in the step stage
  always_comb begin
    s1_wr.en   = s1_valid && s1_lane_ok &&
                 (s1_type == REQ_START || s1_type == REQ_DECODE);
    s1_wr.lane = s1_lane;
    if (s1_type == REQ_DECODE) begin
      s1_wr.ctx.carry = sym[BYTE_W-1 -: CARRY_W];
      s1_wr.ctx.state = base + rd_bits;
    end else begin
      s1_wr.ctx.carry = mirrored ? MIRROR_CARRY : '0;
      s1_wr.ctx.state = s1_bits;
    end
  end

  always_comb begin
    file_wr    = s1_wr;
    file_wr.en = s1_wr.en && s1_adv;
  end

  // Result of the item in the step stage
  always_comb begin
    res_byte   = '0;
    res_bvalid = 1'b0;
    res_bits   = '0;
    if (s1_lane_ok) begin
      case (s1_type)
        REQ_START: begin
          res_bits = NB_W'(TABLE_LOG);
        end
        REQ_DECODE: begin
          res_byte   = mirrored ? ~sym : sym;
          res_bvalid = 1'b1;
          res_bits   = nb;
        end
        default: begin
          res_bits = '0;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte   <= res_byte;
      out_bvalid <= res_bvalid;
      out_bits   <= res_bits;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.out_byte   = out_byte;
  assign rsp.byte_valid = out_bvalid;
  assign rsp.bits_used  = out_bits;

`ifndef SYNTHESIS
  // Single-port use of the table: never a load and a decode read together
  assert property (@(posedge clk) disable iff (rst) !(tbl_we && tbl_re))
    else $error("table read and write in the same cycle");

  // An accepted request always occupies the step stage next cycle
  assert property (@(posedge clk) disable iff (rst) accept |=> s1_valid)
    else $error("accepted request lost before step stage");

  // Non-decode results carry no byte
  assert property (@(posedge clk) disable iff (rst)
                   rsp.valid && !rsp.byte_valid |-> rsp.out_byte == '0)
    else $error("byte on a non-decode result");

  // Consumed bit count never exceeds the table log
  assert property (@(posedge clk) disable iff (rst)
                   rsp.valid |-> rsp.bits_used <= NB_W'(TABLE_LOG))
    else $error("bits_used above table log");

  // A stalled step stage blocks new requests
  assert property (@(posedge clk) disable iff (rst)
                   s1_valid && out_valid && !rsp.ready |-> !req.ready)
    else $error("request taken while step stage stalled");
`endif

endmodule
